FILE: hw/rtl/pidpl_pkg.sv
// shared types, constants and register codes of the pid position loop
package pidpl_pkg;

  // field widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned ErrW   = 33;
  localparam int unsigned DiffW  = 34;
  localparam int unsigned LimW   = 31;
  localparam int unsigned FracW  = 16;
  localparam int unsigned TermW  = 50;
  localparam int unsigned SumW   = 52;
  localparam int unsigned IdxW   = 3;

  // error band inside which the integral is dropped
  localparam logic signed [ErrW-1:0] SmallErrPos = 33'sd10;
  localparam logic signed [ErrW-1:0] SmallErrNeg = -33'sd10;

  // register reset values
  localparam logic signed [DataW-1:0] PGainRst  = 32'sd8192;
  localparam logic signed [DataW-1:0] IGainRst  = 32'sd2048;
  localparam logic signed [DataW-1:0] DGainRst  = 32'sd4096;
  localparam logic signed [DataW-1:0] TargetRst = 32'sd0;
  localparam logic signed [DataW-1:0] UpperRst  = 32'sd50000;
  localparam logic signed [DataW-1:0] LowerRst  = -32'sd50000;
  localparam logic [LimW-1:0]         LimitRst  = 31'd32768;

  // item kinds
  typedef enum logic [1:0] {
    KindSample = 2'd0,
    KindStart  = 2'd1,
    KindStop   = 2'd2,
    KindClear  = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [IdxW-1:0] {
    RegPGain  = 3'd0,
    RegIGain  = 3'd1,
    RegDGain  = 3'd2,
    RegTarget = 3'd3,
    RegUpper  = 3'd4,
    RegLower  = 3'd5,
    RegLimit  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [DataW-1:0] p_gain;
    logic signed [DataW-1:0] i_gain;
    logic signed [DataW-1:0] d_gain;
    logic signed [DataW-1:0] target_position;
    logic signed [DataW-1:0] output_upper;
    logic signed [DataW-1:0] output_lower;
    logic [LimW-1:0]         integral_limit;
  } cfg_t;

  // operands of one item after the error and integral update
  typedef struct packed {
    logic                    sample;
    logic                    running;
    logic signed [ErrW-1:0]  err;
    logic signed [DataW-1:0] integ;
    logic signed [DiffW-1:0] diff;
  } oper_t;

  // scaled p, i and d terms of one item
  typedef struct packed {
    logic                    sample;
    logic                    running;
    logic signed [TermW-1:0] p_term;
    logic signed [TermW-1:0] i_term;
    logic signed [TermW-1:0] d_term;
  } terms_t;

endpackage

FILE: hw/rtl/pidpl_if.sv
// valid/ready channels of the pid position loop
interface pidpl_in_if
  import pidpl_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic signed [DataW-1:0] measured_position;

  modport source (output valid, output kind, output measured_position, input ready);
  modport sink   (input valid, input kind, input measured_position, output ready);
endinterface

interface pidpl_out_if
  import pidpl_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] drive;
  logic                    running;

  modport source (output valid, output drive, output running, input ready);
  modport sink   (input valid, input drive, input running, output ready);
endinterface

interface pidpl_cfg_if
  import pidpl_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  index;
  logic [DataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/pidpl_cfg_regs.sv
// configuration register file of the pid position loop
module pidpl_cfg_regs
  import pidpl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pidpl_cfg_if.sink   cfg,
  output cfg_t        regs
);

  cfg_t regs_next;

  // writes always complete at once
  assign cfg.ready = 1'b1;

  // decode the register index
  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        RegPGain:  regs_next.p_gain          = $signed(cfg.data);
        RegIGain:  regs_next.i_gain          = $signed(cfg.data);
        RegDGain:  regs_next.d_gain          = $signed(cfg.data);
        RegTarget: regs_next.target_position = $signed(cfg.data);
        RegUpper:  regs_next.output_upper    = $signed(cfg.data);
        RegLower:  regs_next.output_lower    = $signed(cfg.data);
        RegLimit:  regs_next.integral_limit  = cfg.data[LimW-1:0];
        default:   regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.p_gain          <= PGainRst;
      regs.i_gain          <= IGainRst;
      regs.d_gain          <= DGainRst;
      regs.target_position <= TargetRst;
      regs.output_upper    <= UpperRst;
      regs.output_lower    <= LowerRst;
      regs.integral_limit  <= LimitRst;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

FILE: hw/rtl/pidpl_front.sv
// input register, error, integral and loop state of the pid position loop
module pidpl_front
  import pidpl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       regs,
  pidpl_in_if.sink   item_in,
  output logic       oper_valid,
  input  logic       oper_ready,
  output oper_t      oper
);

  // input register
  logic                    in_valid;
  logic [1:0]              in_kind;
  logic signed [DataW-1:0] in_pos;

  // loop state
  logic                    enabled;
  logic signed [DataW-1:0] integral_sum;
  logic signed [ErrW-1:0]  previous_error;
  logic                    enabled_next;
  logic signed [DataW-1:0] integral_sum_next;
  logic signed [ErrW-1:0]  previous_error_next;

  logic signed [ErrW-1:0]  err;
  logic signed [DiffW-1:0] acc;
  logic signed [DiffW-1:0] lim_pos;
  logic signed [DiffW-1:0] lim_neg;
  logic signed [DiffW-1:0] acc_clamped;
  logic                    small_err;
  logic                    advance;

  assign item_in.ready = !in_valid || oper_ready;
  assign advance       = in_valid && oper_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      in_kind <= item_in.kind;
      in_pos  <= item_in.measured_position;
    end
  end

  // error, clamped integral and error difference
  always_comb begin
    err = ErrW'(regs.target_position) - ErrW'(in_pos);
    acc = DiffW'(integral_sum) + DiffW'(err);
    lim_pos = $signed({{(DiffW-LimW){1'b0}}, regs.integral_limit});
    lim_neg = -lim_pos;
    if (acc < lim_neg) begin
      acc_clamped = lim_neg;
    end else if (acc > lim_pos) begin
      acc_clamped = lim_pos;
    end else begin
      acc_clamped = acc;
    end
    small_err = (err > SmallErrNeg) && (err < SmallErrPos);
  end

  // state update per item kind
  always_comb begin
    enabled_next        = enabled;
    integral_sum_next   = integral_sum;
    previous_error_next = previous_error;
    unique case (kind_t'(in_kind))
      KindStart: begin
        enabled_next        = 1'b1;
        integral_sum_next   = '0;
        previous_error_next = '0;
      end
      KindStop: begin
        enabled_next = 1'b0;
      end
      KindClear: begin
        integral_sum_next   = '0;
        previous_error_next = '0;
      end
      KindSample: begin
        if (enabled) begin
          integral_sum_next   = small_err ? '0 : acc_clamped[DataW-1:0];
          previous_error_next = err;
        end
      end
      default: begin
        enabled_next = enabled;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b0;
      integral_sum   <= '0;
      previous_error <= '0;
    end else if (advance) begin
      enabled        <= enabled_next;
      integral_sum   <= integral_sum_next;
      previous_error <= previous_error_next;
    end
  end

  // operands for the term stage
  assign oper_valid   = in_valid;
  assign oper.sample  = (kind_t'(in_kind) == KindSample) && enabled;
  assign oper.running = enabled_next;
  assign oper.err     = err;
  assign oper.integ   = acc_clamped[DataW-1:0];
  assign oper.diff    = DiffW'(err) - DiffW'(previous_error);

endmodule

FILE: hw/rtl/pidpl_terms.sv
// operand register, q16 products and term register of the pid position loop
module pidpl_terms
  import pidpl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    regs,
  input  logic    oper_valid,
  output logic    oper_ready,
  input  oper_t   oper,
  output logic    terms_valid,
  input  logic    terms_ready,
  output terms_t  terms
);

  localparam int unsigned PProdW = DataW + ErrW;
  localparam int unsigned IProdW = DataW + DataW;
  localparam int unsigned DProdW = DataW + DiffW;

  logic                     op_valid;
  oper_t                    op;
  logic                     term_load;
  logic signed [PProdW-1:0] p_prod;
  logic signed [IProdW-1:0] i_prod;
  logic signed [DProdW-1:0] d_prod;
  terms_t                   terms_next;

  assign term_load  = !terms_valid || terms_ready;
  assign oper_ready = !op_valid || term_load;

  // operand register
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (oper_ready) begin
      op_valid <= oper_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (oper_ready && oper_valid) begin
      op <= oper;
    end
  end

  // exact products, floor shift by the fraction width
  always_comb begin
    p_prod = PProdW'(regs.p_gain) * PProdW'(op.err);
    i_prod = IProdW'(regs.i_gain) * IProdW'(op.integ);
    d_prod = DProdW'(regs.d_gain) * DProdW'(op.diff);
    terms_next.sample  = op.sample;
    terms_next.running = op.running;
    terms_next.p_term  = TermW'($signed(p_prod[PProdW-1:FracW]));
    terms_next.i_term  = TermW'($signed(i_prod[IProdW-1:FracW]));
    terms_next.d_term  = TermW'($signed(d_prod[DProdW-1:FracW]));
  end

  // term register
  always_ff @(posedge clk) begin
    if (rst) begin
      terms_valid <= 1'b0;
    end else if (term_load) begin
      terms_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (term_load && op_valid) begin
      terms <= terms_next;
    end
  end

endmodule

FILE: hw/rtl/pidpl_out.sv
// term sum, output clamp and result register of the pid position loop
module pidpl_out
  import pidpl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          regs,
  input  logic          terms_valid,
  output logic          terms_ready,
  input  terms_t        terms,
  pidpl_out_if.source   result_out
);

  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  upper;
  logic signed [SumW-1:0]  lower;
  logic signed [DataW-1:0] drive_next;

  assign terms_ready = !result_out.valid || result_out.ready;

  // sum of the three terms clamped to the bounds, lower bound tested first; zero drive for a non-sample
  always_comb begin
    sum   = SumW'(terms.p_term) + SumW'(terms.i_term) + SumW'(terms.d_term);
    upper = SumW'(regs.output_upper);
    lower = SumW'(regs.output_lower);
    if (!terms.sample) begin
      drive_next = '0;
    end else if (sum < lower) begin
      drive_next = regs.output_lower;
    end else if (sum > upper) begin
      drive_next = regs.output_upper;
    end else begin
      drive_next = sum[DataW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (terms_ready) begin
      result_out.valid <= terms_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (terms_ready && terms_valid) begin
      result_out.drive   <= drive_next;
      result_out.running <= terms.running;
    end
  end

endmodule

FILE: hw/rtl/fixed_point_pid_position_loop_core.sv
// top level of the q16 pid position loop
// Usage:
//   item_in carries kind and measured_position; one result per item leaves on
//   result_out with drive and running. kind selects sample, start, stop or
//   clear state; only a sample taken while the loop runs gives a nonzero drive.
//   cfg writes the gains, target, output bounds and integral limit by index;
//   it is always ready and should only be used while no item is in flight.
// Pipeline and throughput:
//   a result passes the input, operand, term and result registers after its
//   item is accepted. One item per cycle is sustained while result_out is not
//   stalled: the integral and previous-error update is a loop closed within
//   the input stage, the three products sit in their own register stage.
// Reset:
//   rst clears all stage valid bits, the loop state (disabled, integral and
//   previous error zero) and loads the register defaults.
// Stalls:
//   each stage holds its item while the next one is full; item_in.ready
//   falls only once all four stages hold items and result_out is stalled.
module fixed_point_pid_position_loop_core
  import pidpl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  pidpl_in_if.sink      item_in,
  pidpl_out_if.source   result_out,
  pidpl_cfg_if.sink     cfg
);

  cfg_t   regs;
  logic   oper_valid;
  logic   oper_ready;
  oper_t  oper;
  logic   terms_valid;
  logic   terms_ready;
  terms_t terms;

  // configuration registers
  pidpl_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // error and loop state
  pidpl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item_in    (item_in),
    .oper_valid (oper_valid),
    .oper_ready (oper_ready),
    .oper       (oper)
  );

  // p, i and d products
  pidpl_terms u_terms (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .oper_valid  (oper_valid),
    .oper_ready  (oper_ready),
    .oper        (oper),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms)
  );

  // sum, clamp and result register
  pidpl_out u_out (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms),
    .result_out  (result_out)
  );

`ifndef SYNTH
  // no result is pending right after reset
  assert property (@(posedge clk) rst |=> !result_out.valid)
    else $error("result valid after reset");

  // a computed sample only leaves the input stage while the loop runs
  assert property (@(posedge clk) disable iff (rst)
    oper_valid && oper.sample |-> oper.running)
    else $error("sample computed while loop disabled");

  // a term set for a sample carries the running flag
  assert property (@(posedge clk) disable iff (rst)
    terms_valid && terms.sample |-> terms.running)
    else $error("term stage sample without running flag");

  // a nonzero drive only comes from a running loop
  assert property (@(posedge clk) disable iff (rst)
    result_out.valid && (result_out.drive != '0) |-> result_out.running)
    else $error("nonzero drive while loop stopped");
`endif

endmodule
